FILE: hdl/delta_prefix_code_encoder_defines.svh
// Assertion helpers used by dpc_back.
`ifndef DELTA_PREFIX_CODE_ENCODER_DEFINES_SVH
`define DELTA_PREFIX_CODE_ENCODER_DEFINES_SVH

// Checked on every clock edge outside reset.
`define DPC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked on every clock edge, reset included.
`define DPC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

FILE: hdl/dpc_pkg.sv
package dpc_pkg;

  localparam int unsigned SampleW = 8;
  localparam int unsigned CodeW   = 10;  // widest code: prefix + 8 bits
  localparam int unsigned LenW    = 4;
  localparam int unsigned StoreW  = 17;  // up to 7 pending bits + one widest code
  localparam int unsigned CountW  = 5;

  localparam logic [1:0] PrefixZero  = 2'b00;
  localparam logic [1:0] PrefixSmall = 2'b01;
  localparam logic [1:0] PrefixMid   = 2'b10;
  localparam logic [1:0] PrefixBig   = 2'b11;

  localparam logic signed [SampleW-1:0] SmallMin = -8'sd3;
  localparam logic signed [SampleW-1:0] SmallMax = 8'sd2;
  localparam logic signed [SampleW-1:0] MidMin   = -8'sd7;
  localparam logic signed [SampleW-1:0] MidMax   = 8'sd6;

  localparam logic [LenW-1:0] LenZero  = 4'd2;
  localparam logic [LenW-1:0] LenSmall = 4'd5;
  localparam logic [LenW-1:0] LenMid   = 4'd6;
  localparam logic [LenW-1:0] LenBig   = 4'd10;

  localparam logic [7:0] PadByte = 8'hFF;

  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = 1;
  localparam int unsigned QueueCntW  = 2;

  // One classified sample. For a raw first sample, code[7:0] holds the byte.
  typedef struct packed {
    logic             first;
    logic             last;
    logic [LenW-1:0]  nbits;
    logic [CodeW-1:0] code;
  } dpc_op_t;

endpackage

FILE: hdl/dpc_if.sv
interface dpc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] sample;
  logic       first_sample;
  logic       last_sample;

  modport source (output valid, output sample, output first_sample, output last_sample,
                  input ready);
  modport sink (input valid, input sample, input first_sample, input last_sample,
                output ready);
endinterface

interface dpc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       end_of_block;

  modport source (output valid, output out_byte, output end_of_block, input ready);
  modport sink (input valid, input out_byte, input end_of_block, output ready);
endinterface

FILE: hdl/dpc_front.sv
module dpc_front import dpc_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  dpc_in_if.sink       sample_i,
  input  logic         full_i,
  output logic         push_o,
  output dpc_op_t      op_o
);

  logic [SampleW-1:0]        prev_q, prev_d;
  logic [SampleW-1:0]        delta;
  logic signed [SampleW-1:0] sdelta;

  assign sample_i.ready = !full_i;
  assign push_o         = sample_i.valid && !full_i;

  assign delta  = sample_i.sample - prev_q;
  assign sdelta = $signed(delta);

  always_comb begin
    op_o.first = sample_i.first_sample;
    op_o.last  = sample_i.last_sample;
    if (sample_i.first_sample) begin
      op_o.nbits = LenBig;
      op_o.code  = {2'b00, sample_i.sample};
    end else if (delta == '0) begin
      op_o.nbits = LenZero;
      op_o.code  = {8'b0, PrefixZero};
    end else if (sdelta >= SmallMin && sdelta <= SmallMax) begin
      op_o.nbits = LenSmall;
      op_o.code  = {5'b0, PrefixSmall, delta[2:0]};
    end else if (sdelta >= MidMin && sdelta <= MidMax) begin
      op_o.nbits = LenMid;
      op_o.code  = {4'b0, PrefixMid, delta[3:0]};
    end else begin
      op_o.nbits = LenBig;
      op_o.code  = {PrefixBig, delta};
    end
  end

  assign prev_d = push_o ? sample_i.sample : prev_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
    end else begin
      prev_q <= prev_d;
    end
  end

endmodule

FILE: hdl/dpc_queue.sv
module dpc_queue import dpc_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  dpc_op_t push_op_i,
  output logic    full_o,
  input  logic    pop_i,
  output logic    valid_o,
  output dpc_op_t pop_op_o
);

  dpc_op_t                mem_q [QueueDepth];
  logic [QueuePtrW-1:0]   wptr_q, wptr_d, rptr_q, rptr_d;
  logic [QueueCntW-1:0]   cnt_q, cnt_d;

  assign full_o   = (cnt_q == QueueCntW'(QueueDepth));
  assign valid_o  = (cnt_q != '0);
  assign pop_op_o = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push_i) begin
      wptr_d = wptr_q + 1'b1;
    end
    if (pop_i) begin
      rptr_d = rptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= push_op_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

FILE: hdl/dpc_back.sv
module dpc_back import dpc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     op_valid_i,
  input  dpc_op_t  op_i,
  output logic     pop_o,
  dpc_out_if.source code_o
);
  `include "delta_prefix_code_encoder_defines.svh"

  // store_q bits at or above cnt_q are stale and never reach an output byte
  logic [StoreW-1:0] store_q, store_d;
  logic [CountW-1:0] cnt_q, cnt_d;
  logic              flush_q, flush_d;
  logic              raw_last_q, raw_last_d;
  logic              out_valid_q, out_valid_d;
  logic [7:0]        out_byte_q, out_byte_d;
  logic              out_eob_q, out_eob_d;

  logic              has_byte, active, slot_free, emit;
  logic [CountW-1:0] shift;
  logic [LenW-1:0]   pad;
  logic [StoreW-1:0] merged;

  assign has_byte  = (cnt_q >= CountW'(8));
  assign active    = has_byte || flush_q;
  assign slot_free = !out_valid_q || code_o.ready;
  assign pop_o     = op_valid_i && !active;
  assign emit      = active && slot_free;

  assign shift  = cnt_q - CountW'(8);
  assign pad    = LenW'(8) - LenW'(cnt_q);
  assign merged = (store_q << op_i.nbits) | StoreW'(op_i.code);

  always_comb begin
    store_d     = store_q;
    cnt_d       = cnt_q;
    flush_d     = flush_q;
    raw_last_d  = raw_last_q;
    out_byte_d  = out_byte_q;
    out_eob_d   = out_eob_q;
    out_valid_d = code_o.ready ? 1'b0 : out_valid_q;
    if (pop_o) begin
      if (op_i.first) begin
        // raw byte; pending bits of an unfinished block are dropped
        store_d    = StoreW'(op_i.code[7:0]);
        cnt_d      = CountW'(8);
        flush_d    = 1'b0;
        raw_last_d = op_i.last;
      end else begin
        store_d    = merged;
        cnt_d      = cnt_q + CountW'(op_i.nbits);
        flush_d    = op_i.last;
        raw_last_d = 1'b0;
      end
    end else if (emit) begin
      out_valid_d = 1'b1;
      if (has_byte) begin
        out_byte_d = 8'(store_q >> shift);
        out_eob_d  = raw_last_q;
        cnt_d      = cnt_q - CountW'(8);
        raw_last_d = 1'b0;
      end else begin
        // tail padded with ones; all ones when nothing is pending
        out_byte_d = 8'(store_q << pad) | (PadByte >> cnt_q[2:0]);
        out_eob_d  = 1'b1;
        cnt_d      = '0;
        flush_d    = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    store_q    <= store_d;
    out_byte_q <= out_byte_d;
    out_eob_q  <= out_eob_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      flush_q     <= 1'b0;
      raw_last_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      flush_q     <= flush_d;
      raw_last_q  <= raw_last_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign code_o.valid        = out_valid_q;
  assign code_o.out_byte     = out_byte_q;
  assign code_o.end_of_block = out_eob_q;

  `DPC_ASSERT(a_cnt_bound, cnt_q <= CountW'(StoreW), "pending bit count overflow")
  `DPC_ASSERT(a_pop_idle, pop_o |-> !has_byte && !flush_q, "op taken while bytes pending")
  `DPC_ASSERT(a_eob_clears, (emit && out_eob_d) |=> (cnt_q == '0) && !flush_q,
              "state not cleared after end of block")
  `DPC_ASSERT(a_raw_last_cnt, raw_last_q |-> cnt_q == CountW'(8),
              "raw end-of-block flag with wrong bit count")
  `DPC_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |=> !out_valid_q, "output valid during reset")

endmodule

FILE: hdl/delta_prefix_code_encoder.sv
// Channel   Dir  Interface   Payload
// sample_i  in   dpc_in_if   sample[7:0], first_sample, last_sample
// code_o    out  dpc_out_if  out_byte[7:0], end_of_block
//
// A sample is accepted in any cycle the two-entry op queue has room.
// The packer either takes a sample from the queue or emits an output byte, and
// takes no new sample while it holds a whole byte or a flush; the single output
// byte register passes at most one byte per cycle while code_o is ready.
// Asynchronous active-low reset clears the queue, packer and previous sample.
// Output stall holds a packer with a byte due; queue takes samples until full.
module delta_prefix_code_encoder import dpc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  dpc_in_if.sink    sample_i,
  dpc_out_if.source code_o
);

  logic    full, push, pop, op_valid;
  dpc_op_t push_op, pop_op;

  dpc_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .sample_i (sample_i),
    .full_i   (full),
    .push_o   (push),
    .op_o     (push_op)
  );

  dpc_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .push_op_i (push_op),
    .full_o    (full),
    .pop_i     (pop),
    .valid_o   (op_valid),
    .pop_op_o  (pop_op)
  );

  dpc_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .op_valid_i (op_valid),
    .op_i       (pop_op),
    .pop_o      (pop),
    .code_o     (code_o)
  );

endmodule
